/* src/linear_adrc_second_order_assert.svh */
// Assertion macros for the second-order linear ADRC block.
`ifndef LINEAR_ADRC_SECOND_ORDER_ASSERT_SVH
`define LINEAR_ADRC_SECOND_ORDER_ASSERT_SVH

`ifndef SYNTH

// Property that must hold at every clock edge out of reset.
`define LADRC_ASSERT_ALWAYS(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("ladrc assertion failed");

// Antecedent in one cycle implies consequent in the next cycle.
`define LADRC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("ladrc assertion failed");

`else

`define LADRC_ASSERT_ALWAYS(lbl, clk, rst_n, prop)
`define LADRC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

/* src/ladrc_pkg.sv */
// Shared types, constants and saturation helpers for the LADRC block.
`timescale 1ns / 1ps
`default_nettype none

package ladrc_pkg;

	// 48-bit signed fixed-point working value
	typedef logic signed [47:0] fx_t;
	typedef logic signed [50:0] wide_t;

	localparam fx_t FX_MAX = 48'sh7FFF_FFFF_FFFF;
	localparam fx_t FX_MIN = 48'sh8000_0000_0000;

	// register indexes (byte address = 4 * index)
	localparam logic [2:0] REG_WO   = 3'd0;
	localparam logic [2:0] REG_WC   = 3'd1;
	localparam logic [2:0] REG_ZETA = 3'd2;
	localparam logic [2:0] REG_B0   = 3'd3;
	localparam logic [2:0] REG_TS   = 3'd4;
	localparam logic [2:0] REG_UP   = 3'd5;
	localparam logic [2:0] REG_LOW  = 3'd6;

	// multiplier request
	typedef struct packed {
		logic start;
		logic sh32;   // shift product by 32 instead of FRAC_BITS
	} mul_req_t;

	function automatic wide_t ext51(input fx_t x);
		return {{3{x[47]}}, x};
	endfunction

	function automatic fx_t sat48(input wide_t v);
		fx_t r;
		if (!v[50] && (|v[49:47]))
			r = FX_MAX;
		else if (v[50] && !(&v[49:47]))
			r = FX_MIN;
		else
			r = v[47:0];
		return r;
	endfunction

endpackage

`default_nettype wire

/* src/ladrc_mul.sv */
// Iterative 48x48 signed multiplier, 16 bits per cycle, floor shift and saturation.
`timescale 1ns / 1ps
`default_nettype none

module ladrc_mul #(
	parameter int FRAC_BITS = 16
) (
	input  wire                 clk,
	input  wire                 arst_n,
	input  ladrc_pkg::mul_req_t req,
	input  ladrc_pkg::fx_t      a,
	input  ladrc_pkg::fx_t      b,
	output logic                done,
	output ladrc_pkg::fx_t      res
);
	import ladrc_pkg::*;

	logic [47:0] ma_q, mb_q;
	logic        neg_q, sh32_q;
	logic [95:0] acc_q;
	logic [1:0]  cnt_q;
	logic        busy_q, fin_q, done_q;
	fx_t         res_q;

	logic [63:0] pp;
	logic [95:0] ppx;
	logic [95:0] qs, qn;
	logic        rnz;
	fx_t         fin_val;

	// one 48x16 partial product per cycle
	assign pp  = ma_q * mb_q[15:0];
	assign ppx = {32'b0, pp} << {cnt_q, 4'b0000};

	// floor shift of the signed product, then clip to 48 bits
	always_comb begin
		if (sh32_q) begin
			qs  = acc_q >> 32;
			rnz = |acc_q[31:0];
		end else begin
			qs  = acc_q >> FRAC_BITS;
			rnz = |acc_q[FRAC_BITS-1:0];
		end
		qn = qs + {95'b0, neg_q & rnz};
		if (neg_q) begin
			if ((|qn[95:48]) || (qn[47] && (|qn[46:0])))
				fin_val = FX_MIN;
			else
				fin_val = fx_t'(48'd0 - qn[47:0]);
		end else begin
			if (|qn[95:47])
				fin_val = FX_MAX;
			else
				fin_val = fx_t'(qn[47:0]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			fin_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= 2'd0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= 2'd0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 2'd1;
				if (cnt_q == 2'd2) begin
					busy_q <= 1'b0;
					fin_q  <= 1'b1;
				end
			end else if (fin_q) begin
				fin_q  <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (req.start) begin
			ma_q   <= a[47] ? (48'd0 - a) : a;
			mb_q   <= b[47] ? (48'd0 - b) : b;
			neg_q  <= a[47] ^ b[47];
			sh32_q <= req.sh32;
			acc_q  <= 96'd0;
		end else if (busy_q) begin
			acc_q <= acc_q + ppx;
			mb_q  <= mb_q >> 16;
		end else if (fin_q) begin
			res_q <= fin_val;
		end
	end

	assign done = done_q;
	assign res  = res_q;

endmodule

`default_nettype wire

/* src/ladrc_div.sv */
// Restoring divider: (u * 2^FRAC_BITS) / d, one quotient bit per cycle, toward zero.
`timescale 1ns / 1ps
`default_nettype none

module ladrc_div #(
	parameter int FRAC_BITS = 16
) (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                start,
	input  ladrc_pkg::fx_t     u,
	input  wire signed [31:0]  d,
	output logic               done,
	output ladrc_pkg::fx_t     quot
);
	import ladrc_pkg::*;

	localparam int NW = 48 + FRAC_BITS;
	localparam int CW = $clog2(NW + 1);

	logic [NW-1:0] n_q, q_q;
	logic [31:0]   md_q, r_q;
	logic          neg_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q, fin_q, done_q;
	fx_t           quot_q;

	logic [32:0] rs, rd;
	logic        ge;
	logic [47:0] mu;
	fx_t         fin_val;

	assign mu = u[47] ? (48'd0 - u) : u;

	// one restoring step
	assign rs = {r_q, n_q[NW-1]};
	assign rd = rs - {1'b0, md_q};
	assign ge = !rd[32];

	// sign and saturate the magnitude quotient
	always_comb begin
		if (|q_q[NW-1:47])
			fin_val = neg_q ? FX_MIN : FX_MAX;
		else if (neg_q)
			fin_val = fx_t'(48'd0 - q_q[47:0]);
		else
			fin_val = fx_t'(q_q[47:0]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			fin_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(NW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CW'(1);
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					fin_q  <= 1'b1;
				end
			end else if (fin_q) begin
				fin_q  <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			n_q   <= {mu, {FRAC_BITS{1'b0}}};
			md_q  <= d[31] ? (32'd0 - d) : d;
			neg_q <= u[47] ^ d[31];
			r_q   <= 32'd0;
			q_q   <= '0;
		end else if (busy_q) begin
			r_q <= ge ? rd[31:0] : rs[31:0];
			n_q <= n_q << 1;
			q_q <= {q_q[NW-2:0], ge};
		end else if (fin_q) begin
			quot_q <= fin_val;
		end
	end

	assign done = done_q;
	assign quot = quot_q;

endmodule

`default_nettype wire

/* src/linear_adrc_second_order.sv */
// Top level of the second-order linear ADRC: registers, sequencer and observer state.
//
//  Channel  Dir  Signals                                  Contents
//  s_*      in   s_tvalid s_tready s_tdata[63:0]          reference, feedback
//  m_*      out  m_tvalid m_tready m_tdata[31:0] m_tuser  drive, clamped
//  apb      in   psel penable pwrite paddr pwdata prdata  seven config registers
//
// Each item runs thirteen products in turn on the single 16-bit-slice multiplier, then
// the divider at one bit per cycle; zero plant gain skips the divider.
// s_tready is high only while the sequencer is idle; a result waiting in the output
// register does not block the next item, but its result waits until that one is taken.
// Reset clears the configuration registers, observer state and last drive.
`timescale 1ns / 1ps
`default_nettype none

`include "linear_adrc_second_order_assert.svh"

module linear_adrc_second_order #(
	parameter int FRAC_BITS = 16
) (
	input  wire         clk,
	input  wire         arst_n,
	// apb
	input  wire         psel,
	input  wire         penable,
	input  wire         pwrite,
	input  wire  [4:0]  paddr,
	input  wire  [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	// input items
	input  wire         s_tvalid,
	output logic        s_tready,
	input  wire  [63:0] s_tdata,   // [31:0] reference, [63:32] feedback
	// result items
	output logic        m_tvalid,
	input  wire         m_tready,
	output logic [31:0] m_tdata,   // [31:0] drive
	output logic [0:0]  m_tuser    // [0] clamped
);
	import ladrc_pkg::*;

	typedef enum logic [6:0] {
		S_IDLE   = 7'b0000001,
		S_MISSUE = 7'b0000010,
		S_MWAIT  = 7'b0000100,
		S_DISSUE = 7'b0001000,
		S_DWAIT  = 7'b0010000,
		S_DONE   = 7'b0100000,
		S_SPARE  = 7'b1000000
	} state_t;

	typedef enum logic [3:0] {
		ST_WO2, ST_B3, ST_L1, ST_L2, ST_D0, ST_PB, ST_D1,
		ST_D2, ST_Z0, ST_Z1, ST_Z2, ST_PU, ST_U
	} step_t;

	state_t state_q;
	step_t  step_q;

	// configuration
	logic [30:0]        wo_q, wc_q, zeta_q;
	logic signed [31:0] b0_q, up_q, low_q;
	logic [31:0]        ts_q;

	// observer state
	fx_t                z0_q, z1_q, z2_q;
	logic signed [31:0] last_q;

	// per-item working values
	logic signed [31:0] ref_q;
	fx_t e_q, wo2_q, b3_q, l1_q, l2_q, d0_q, d1_q, d2_q, acc_q, u_q, quot_q;

	// output register
	logic               m_valid_q;
	logic signed [31:0] m_drive_q;
	logic               m_clamp_q;

	mul_req_t mreq;
	fx_t      ma, mb, mres;
	logic     mdone;
	logic     dstart, ddone;
	fx_t      dquot;

	logic  apb_wr, s_acc, out_free;
	fx_t   b1, b2, fbx, upx, lowx, qv;
	logic  clamp;

	assign pready   = 1'b1;
	assign apb_wr   = psel & penable & pwrite;
	assign s_tready = (state_q == S_IDLE);
	assign s_acc    = s_tvalid & s_tready;
	assign out_free = !m_valid_q || m_tready;

	// gains that need no multiplier
	assign b1  = fx_t'({17'b0, wo_q, 1'b0}) + fx_t'({17'b0, wo_q});
	assign b2  = sat48(ext51(wo2_q) + ext51(wo2_q) + ext51(wo2_q));
	assign fbx = fx_t'($signed(s_tdata[63:32]));

	// register read
	always_comb begin
		case (paddr[4:2])
			REG_WO:   prdata = {1'b0, wo_q};
			REG_WC:   prdata = {1'b0, wc_q};
			REG_ZETA: prdata = {1'b0, zeta_q};
			REG_B0:   prdata = b0_q;
			REG_TS:   prdata = ts_q;
			REG_UP:   prdata = up_q;
			REG_LOW:  prdata = low_q;
			default:  prdata = 32'd0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wo_q   <= '0;
			wc_q   <= '0;
			zeta_q <= '0;
			b0_q   <= '0;
			ts_q   <= '0;
			up_q   <= '0;
			low_q  <= '0;
		end else if (apb_wr) begin
			case (paddr[4:2])
				REG_WO:   wo_q   <= pwdata[30:0];
				REG_WC:   wc_q   <= pwdata[30:0];
				REG_ZETA: zeta_q <= pwdata[30:0];
				REG_B0:   b0_q   <= pwdata;
				REG_TS:   ts_q   <= pwdata;
				REG_UP:   up_q   <= pwdata;
				REG_LOW:  low_q  <= pwdata;
				default: ;
			endcase
		end
	end

	// operand select for the shared multiplier
	always_comb begin
		mreq.start = (state_q == S_MISSUE);
		mreq.sh32  = 1'b0;
		ma = '0;
		mb = '0;
		case (step_q)
			ST_WO2: begin ma = fx_t'({17'b0, wo_q}); mb = fx_t'({17'b0, wo_q}); end
			ST_B3:  begin ma = wo2_q; mb = fx_t'({17'b0, wo_q}); end
			ST_L1:  begin ma = fx_t'({17'b0, zeta_q}); mb = fx_t'({17'b0, wc_q}); end
			ST_L2:  begin ma = fx_t'({17'b0, wc_q}); mb = fx_t'({17'b0, wc_q}); end
			ST_D0:  begin ma = b1; mb = e_q; end
			ST_PB:  begin ma = b2; mb = e_q; end
			ST_D1:  begin ma = fx_t'(b0_q); mb = fx_t'(last_q); end
			ST_D2:  begin ma = b3_q; mb = e_q; end
			ST_Z0:  begin ma = fx_t'({16'b0, ts_q}); mb = d0_q; mreq.sh32 = 1'b1; end
			ST_Z1:  begin ma = fx_t'({16'b0, ts_q}); mb = d1_q; mreq.sh32 = 1'b1; end
			ST_Z2:  begin ma = fx_t'({16'b0, ts_q}); mb = d2_q; mreq.sh32 = 1'b1; end
			ST_PU:  begin ma = l2_q; mb = sat48(ext51(fx_t'(ref_q)) - ext51(z0_q)); end
			ST_U:   begin ma = l1_q; mb = z1_q; end
			default: ;
		endcase
	end

	ladrc_mul #(.FRAC_BITS(FRAC_BITS)) u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mreq),
		.a      (ma),
		.b      (mb),
		.done   (mdone),
		.res    (mres)
	);

	assign dstart = (state_q == S_DISSUE);

	ladrc_div #(.FRAC_BITS(FRAC_BITS)) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (dstart),
		.u      (u_q),
		.d      (b0_q),
		.done   (ddone),
		.quot   (dquot)
	);

	// clamp: upper first, then lower wins
	always_comb begin
		upx   = fx_t'(up_q);
		lowx  = fx_t'(low_q);
		qv    = quot_q;
		clamp = 1'b0;
		if (qv > upx) begin
			qv    = upx;
			clamp = 1'b1;
		end
		if (qv < lowx) begin
			qv    = lowx;
			clamp = 1'b1;
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			step_q    <= ST_WO2;
			m_valid_q <= 1'b0;
		end else begin
			// a new result replaces the one taken in the same cycle
			if (state_q == S_DONE && out_free)
				m_valid_q <= 1'b1;
			else if (m_valid_q && m_tready)
				m_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (s_acc) begin
						step_q  <= ST_WO2;
						state_q <= S_MISSUE;
					end
				end
				S_MISSUE: state_q <= S_MWAIT;
				S_MWAIT: begin
					if (mdone) begin
						if (step_q == ST_U)
							state_q <= (b0_q == 32'sd0) ? S_DONE : S_DISSUE;
						else begin
							step_q  <= step_t'(step_q + 4'd1);
							state_q <= S_MISSUE;
						end
					end
				end
				S_DISSUE: state_q <= S_DWAIT;
				S_DWAIT: begin
					if (ddone)
						state_q <= S_DONE;
				end
				S_DONE: begin
					if (out_free)
						state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// observer state and last drive
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			z0_q   <= '0;
			z1_q   <= '0;
			z2_q   <= '0;
			last_q <= '0;
		end else begin
			if (state_q == S_MWAIT && mdone) begin
				case (step_q)
					ST_Z0:   z0_q <= sat48(ext51(z0_q) + ext51(mres));
					ST_Z1:   z1_q <= sat48(ext51(z1_q) + ext51(mres));
					ST_Z2:   z2_q <= sat48(ext51(z2_q) + ext51(mres));
					default: ;
				endcase
			end
			if (state_q == S_DONE && out_free)
				last_q <= qv[31:0];
		end
	end

	// working values and output payload
	always_ff @(posedge clk) begin
		if (s_acc) begin
			ref_q <= $signed(s_tdata[31:0]);
			e_q   <= sat48(ext51(fbx) - ext51(z0_q));
		end
		if (state_q == S_MWAIT && mdone) begin
			case (step_q)
				ST_WO2: wo2_q <= mres;
				ST_B3:  b3_q  <= mres;
				ST_L1:  l1_q  <= sat48(ext51(mres) + ext51(mres));
				ST_L2:  l2_q  <= mres;
				ST_D0:  d0_q  <= sat48(ext51(mres) + ext51(z1_q));
				ST_PB:  acc_q <= mres;
				ST_D1:  d1_q  <= sat48(ext51(acc_q) + ext51(z2_q) + ext51(mres));
				ST_D2:  d2_q  <= mres;
				ST_PU:  acc_q <= mres;
				ST_U:   u_q   <= sat48(ext51(acc_q) - ext51(mres) - ext51(z2_q));
				default: ;
			endcase
			if (step_q == ST_U)
				quot_q <= '0;
		end
		if (state_q == S_DWAIT && ddone)
			quot_q <= dquot;
		if (state_q == S_DONE && out_free) begin
			m_drive_q <= qv[31:0];
			m_clamp_q <= clamp;
		end
	end

	assign m_tvalid   = m_valid_q;
	assign m_tdata    = m_drive_q;
	assign m_tuser[0] = m_clamp_q;

	// checks
	`LADRC_ASSERT_ALWAYS(a_mul_done_in_wait, clk, arst_n, !mdone || state_q == S_MWAIT)
	`LADRC_ASSERT_ALWAYS(a_div_done_in_wait, clk, arst_n, !ddone || state_q == S_DWAIT)
	`LADRC_ASSERT_ALWAYS(a_unclamped_in_range, clk, arst_n,
		!(m_valid_q && !m_clamp_q) || (m_drive_q <= up_q && m_drive_q >= low_q))
	`LADRC_ASSERT_NEXT(a_accept_starts_seq, clk, arst_n, s_acc,
		state_q == S_MISSUE && step_q == ST_WO2)

endmodule

`default_nettype wire
